// ----- hdl/cdpb_pkg.sv -----
package cdpb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam int THR_W      = 26;
  localparam int STG_W      = 8;
  localparam int BIN_W      = 9;
  localparam int TOF_W      = 32;

  localparam int unsigned TUBE_LEN        = 300;
  localparam int unsigned COEF_GAIN_MILLI = 280084;
  localparam int unsigned COEF_OFFS_MILLI = 153283;
  localparam int unsigned RATIO_LIMIT     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_STAGE_COUNT = 2'd1,
    CFG_BIN_COUNT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [STG_W-1:0] stage_count;
    logic [BIN_W-1:0] bin_count;
  } cfg_t;

endpackage

// ----- hdl/cdpb_in_if.sv -----
interface cdpb_in_if
  import cdpb_pkg::*;
#(
  parameter int CHARGE_WIDTH = 24,
  parameter int TUBE_WIDTH   = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHARGE_WIDTH-1:0] charge_upper;
  logic [CHARGE_WIDTH-1:0] charge_lower;
  logic [CHARGE_WIDTH-1:0] baseline_upper;
  logic [CHARGE_WIDTH-1:0] baseline_lower;
  logic [TUBE_WIDTH-1:0]   tube_index;
  logic [TOF_W-1:0]        time_of_flight;

  modport source (
    output valid, charge_upper, charge_lower, baseline_upper, baseline_lower,
           tube_index, time_of_flight,
    input  ready
  );
  modport sink (
    input  valid, charge_upper, charge_lower, baseline_upper, baseline_lower,
           tube_index, time_of_flight,
    output ready
  );
endinterface

// ----- hdl/cdpb_out_if.sv -----
interface cdpb_out_if
  import cdpb_pkg::*;
#(
  parameter int TUBE_WIDTH = 8
);
  logic                  valid;
  logic                  ready;
  logic [BIN_W-1:0]      position_bin;
  logic [TUBE_WIDTH-1:0] tube_out;
  logic [TOF_W-1:0]      tof_out;

  modport source (
    output valid, position_bin, tube_out, tof_out,
    input  ready
  );
  modport sink (
    input  valid, position_bin, tube_out, tof_out,
    output ready
  );
endinterface

// ----- hdl/charge_division_position_binner_unit.sv -----
// Charge division position binner.
// The hit channel takes one transaction per detector hit: both end charges, their
// baseline sums, the tube number and the time of flight. The result channel gives
// at most one transaction per hit, with the position bin, tube and time of flight;
// hits below the charge threshold or outside the tube are dropped silently.
// The three configuration registers must be written through cfg_wr_en, cfg_index and
// cfg_data only while no hit is in flight; the block itself does not enforce this.
// A hit may be accepted in every cycle in which hit.ready is high. Its result passes
// through the bit-per-stage dividers for the baseline correction, the position
// ratio and the bin index.
// The whole pipeline advances together: when the result register holds a
// transaction that the receiver does not take, every stage holds and hit.ready
// drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with threshold 1, stage
// count 1 and 300 bins.
module charge_division_position_binner_unit
  import cdpb_pkg::*;
#(
  parameter int CHARGE_WIDTH  = 24,
  parameter int FRACTION_BITS = 16,
  parameter int TUBE_WIDTH    = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdpb_in_if.sink               hit,
  cdpb_out_if.source            result
);
  localparam int CW   = CHARGE_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int SW   = CW + 2;
  localparam int NWR  = CW + 1 + F;
  localparam int RW   = F + 4;
  localparam int PW   = 2 * F + 15;
  localparam int CMPW = (CW + 1 > THR_W) ? CW + 1 : THR_W;

  localparam longint unsigned COEF_A = ((64'(COEF_GAIN_MILLI) << F) + 64'd500) / 64'd1000;
  localparam longint unsigned COEF_B = ((64'(COEF_OFFS_MILLI) << F) + 64'd500) / 64'd1000;
  localparam logic signed [F+9:0]  COEF_A_S  = (F + 10)'(COEF_A);
  localparam logic [F+2:0]         RATIO_LIM = (F + 3)'(RATIO_LIMIT) << F;
  localparam logic signed [PW-1:0] POS_OFFS  = PW'(COEF_B << F);
  localparam logic signed [PW-1:0] POS_TOP   = PW'(64'(TUBE_LEN) << (2 * F));

  typedef struct packed {
    logic [TUBE_WIDTH-1:0] tube;
    logic [TOF_W-1:0]      tof;
    logic [CW-1:0]         qu;
    logic [CW-1:0]         ql;
  } side1_t;

  typedef struct packed {
    logic [TUBE_WIDTH-1:0] tube;
    logic [TOF_W-1:0]      tof;
    logic                  neg;
  } side2_t;

  typedef struct packed {
    logic [TUBE_WIDTH-1:0] tube;
    logic [TOF_W-1:0]      tof;
  } side3_t;

  cfg_t cfg;
  logic en;

  logic res_valid;
  logic [BIN_W-1:0]      res_bin;
  logic [TUBE_WIDTH-1:0] res_tube;
  logic [TOF_W-1:0]      res_tof;

  assign en        = !res_valid || result.ready;
  assign hit.ready = en;

  cdpb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Baseline sums divided by the stage count.
  side1_t        side1_in;
  side1_t        side1_out;
  logic          v_d1;
  logic [CW-1:0] du;
  logic [CW-1:0] dl;
  logic [STG_W-1:0] mu;
  logic [STG_W-1:0] ml;

  assign side1_in = '{tube: hit.tube_index, tof: hit.time_of_flight,
                      qu: hit.charge_upper, ql: hit.charge_lower};

  cdpb_div #(.NW(CW), .DW(STG_W)) u_div_bu (
    .clk (clk), .en (en), .num (hit.baseline_upper), .den (cfg.stage_count),
    .quo (du), .rem (mu)
  );

  cdpb_div #(.NW(CW), .DW(STG_W)) u_div_bl (
    .clk (clk), .en (en), .num (hit.baseline_lower), .den (cfg.stage_count),
    .quo (dl), .rem (ml)
  );

  cdpb_dly #(.W($bits(side1_t)), .D(CW)) u_dly1 (
    .clk (clk), .rst (rst), .en (en),
    .vld_i (hit.valid), .dat_i (side1_in),
    .vld_o (v_d1), .dat_o (side1_out)
  );

  // Corrected charges, sum, difference and threshold test.
  logic signed [CW:0]   a_c;
  logic signed [CW:0]   b_c;
  logic signed [SW-1:0] sum_c;
  logic signed [SW-1:0] diff_c;
  logic signed [SW-1:0] absd_c;
  logic                 keep1_c;

  always_comb begin
    a_c = $signed({1'b0, side1_out.qu}) - $signed({1'b0, du})
        - $signed({{CW{1'b0}}, (mu != '0) && (side1_out.qu > du)});
    b_c = $signed({1'b0, side1_out.ql}) - $signed({1'b0, dl})
        - $signed({{CW{1'b0}}, (ml != '0) && (side1_out.ql > dl)});
    sum_c   = SW'(a_c) + SW'(b_c);
    diff_c  = SW'(a_c) - SW'(b_c);
    absd_c  = diff_c[SW-1] ? -diff_c : diff_c;
    keep1_c = v_d1 && (sum_c > 0)
           && (CMPW'(sum_c[CW:0]) >= CMPW'(cfg.threshold));
  end

  logic          v1;
  logic [CW:0]   sum1;
  logic [CW:0]   absd1;
  side2_t        side2_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= keep1_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1     <= sum_c[CW:0];
      absd1    <= absd_c[CW:0];
      side2_in <= '{tube: side1_out.tube, tof: side1_out.tof, neg: diff_c[SW-1]};
    end
  end

  // Ratio magnitude |a-b| * 2^F / (a+b).
  logic [NWR-1:0] ratio_q;
  logic [CW:0]    ratio_rem;
  side2_t         side2_out;
  logic           v_d2;

  cdpb_div #(.NW(NWR), .DW(CW + 1)) u_div_ratio (
    .clk (clk), .en (en), .num ({absd1, {F{1'b0}}}), .den (sum1),
    .quo (ratio_q), .rem (ratio_rem)
  );

  cdpb_dly #(.W($bits(side2_t)), .D(NWR)) u_dly2 (
    .clk (clk), .rst (rst), .en (en),
    .vld_i (v1), .dat_i (side2_in),
    .vld_o (v_d2), .dat_o (side2_out)
  );

  // Saturate and sign the ratio.
  logic [F+2:0]         mag_c;
  logic                 v2;
  logic signed [RW-1:0] r2;
  side3_t               side2;

  assign mag_c = (ratio_q > NWR'(RATIO_LIM)) ? RATIO_LIM : ratio_q[F+2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v_d2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2    <= side2_out.neg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
      side2 <= '{tube: side2_out.tube, tof: side2_out.tof};
    end
  end

  // Gain product.
  logic                     v3;
  logic signed [2*F+13:0]   prod3;
  side3_t                   side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3 <= COEF_A_S * r2;
      side3 <= side2;
    end
  end

  // Offset, range test and integer part of the position.
  logic signed [PW-1:0] pos_c;
  logic                 keep4_c;
  logic                 v4;
  logic [BIN_W-1:0]     ip4;
  side3_t               side4;

  assign pos_c   = PW'(prod3) + POS_OFFS;
  assign keep4_c = v3 && !pos_c[PW-1] && (pos_c <= POS_TOP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= keep4_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip4   <= pos_c[2*F+BIN_W-1:2*F];
      side4 <= side3;
    end
  end

  // Bin width 300 / bins follows the register on its own.
  logic [BIN_W-1:0] bin_w;
  logic [BIN_W-1:0] bin_w_rem;

  cdpb_div #(.NW(BIN_W), .DW(BIN_W)) u_div_width (
    .clk (clk), .en (1'b1), .num (BIN_W'(TUBE_LEN)), .den (cfg.bin_count),
    .quo (bin_w), .rem (bin_w_rem)
  );

  // Bin index.
  logic [BIN_W-1:0] bin_q;
  logic [BIN_W-1:0] bin_rem;
  side3_t           side5;
  logic             v_d3;

  cdpb_div #(.NW(BIN_W), .DW(BIN_W)) u_div_bin (
    .clk (clk), .en (en), .num (ip4), .den (bin_w),
    .quo (bin_q), .rem (bin_rem)
  );

  cdpb_dly #(.W($bits(side3_t)), .D(BIN_W)) u_dly3 (
    .clk (clk), .rst (rst), .en (en),
    .vld_i (v4), .dat_i (side4),
    .vld_o (v_d3), .dat_o (side5)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v_d3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_bin  <= bin_q + BIN_W'(1);
      res_tube <= side5.tube;
      res_tof  <= side5.tof;
    end
  end

  assign result.valid        = res_valid;
  assign result.position_bin = res_bin;
  assign result.tube_out     = res_tube;
  assign result.tof_out      = res_tof;
endmodule

// ----- hdl/cdpb_cfg.sv -----
module cdpb_cfg
  import cdpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);
  logic [THR_W-1:0] threshold;
  logic [STG_W-1:0] stage_count;
  logic [BIN_W-1:0] bin_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THR_W'(1);
      stage_count <= STG_W'(1);
      bin_count   <= BIN_W'(TUBE_LEN);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:   threshold   <= cfg_data[THR_W-1:0];
        CFG_STAGE_COUNT: stage_count <= cfg_data[STG_W-1:0];
        CFG_BIN_COUNT:   bin_count   <= cfg_data[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero divisors act as one; more bins than tube units act as one bin per unit.
  always_comb begin
    cfg.threshold   = threshold;
    cfg.stage_count = (stage_count == '0) ? STG_W'(1) : stage_count;
    if (bin_count == '0) begin
      cfg.bin_count = BIN_W'(1);
    end else if (bin_count > BIN_W'(TUBE_LEN)) begin
      cfg.bin_count = BIN_W'(TUBE_LEN);
    end else begin
      cfg.bin_count = bin_count;
    end
  end
endmodule

// ----- hdl/cdpb_div.sv -----
module cdpb_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  // One restoring quotient bit per stage, most significant first.
  logic [NW-1:0] num_s [1:NW];
  logic [NW-1:0] quo_s [1:NW];
  logic [DW-1:0] rem_s [1:NW];
  logic [DW-1:0] den_s [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_in = num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign num_in = num_s[k];
      assign quo_in = quo_s[k];
      assign rem_in = rem_s[k];
      assign den_in = den_s[k];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        num_s[k+1] <= num_in << 1;
        quo_s[k+1] <= NW'({quo_in, ge});
        rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_s[k+1] <= den_in;
      end
    end
  end

  assign quo = quo_s[NW];
  assign rem = rem_s[NW];
endmodule

// ----- hdl/cdpb_dly.sv -----
module cdpb_dly #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);
  logic [D-1:0] vld;
  logic [W-1:0] dat [0:D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= vld_i;
      for (int i = 1; i < D; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat[0] <= dat_i;
      for (int i = 1; i < D; i++) begin
        dat[i] <= dat[i-1];
      end
    end
  end

  assign vld_o = vld[D-1];
  assign dat_o = dat[D-1];
endmodule
